/* design/gcm_pkg.sv */
// Shared types and constants for the greedy change maker.
package gcm_pkg;

    // Field widths
    localparam int CENTS_W    = 24;
    localparam int COIN_W     = 16;
    localparam int SLOT_IDX_W = 3;
    localparam int SLOT_REGS  = 8;

    // Divider steps per slot: one quotient bit per cycle
    localparam int DIV_STEPS  = CENTS_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_EMIT
    } gcm_state_t;

endpackage

/* design/gcm_in_if.sv */
// Request channel: one change amount per transfer.
interface gcm_in_if;
    logic                         valid;
    logic                         ready;
    logic [gcm_pkg::CENTS_W-1:0]  change_cents;

    modport source (output valid, output change_cents, input ready);
    modport sink   (input valid, input change_cents, output ready);
endinterface

/* design/gcm_out_if.sv */
// Result channel: one denomination slot and its coin count per transfer.
interface gcm_out_if;
    logic                           valid;
    logic                           ready;
    logic [gcm_pkg::SLOT_IDX_W-1:0] slot_index;
    logic [gcm_pkg::COIN_W-1:0]     coin_value;
    logic [gcm_pkg::CENTS_W-1:0]    coin_count;
    logic                           last_slot;

    modport source (output valid, output slot_index, output coin_value,
                    output coin_count, output last_slot, input ready);
    modport sink   (input valid, input slot_index, input coin_value,
                    input coin_count, input last_slot, output ready);
endinterface

/* design/greedy_change_maker.sv */
// Greedy coin change maker: top level with slot sequencer and serial divider.
//
// Each change amount (cents) accepted on the request channel produces exactly
// NUM_COINS results on the result channel, one per denomination slot in slot
// order, with the last one flagged. A slot whose denomination is zero gets a
// count of zero and leaves the remainder untouched; any amount left after the
// final slot is dropped. Denominations must be written through the cfg port
// only while the block is idle; the block itself does not enforce this. The
// request channel is ready only when no amount is in work. Each nonzero slot
// runs a setup state, the shared one-bit-per-cycle restoring divider and a
// state that presents the result until ready; a zero slot skips the divider.
module greedy_change_maker #(
    parameter int NUM_COINS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gcm_pkg::SLOT_IDX_W-1:0]    cfg_index,
    input  logic [gcm_pkg::COIN_W-1:0]        cfg_data,
    gcm_in_if.sink                            request,
    gcm_out_if.source                         result
);

    localparam int SLOT_W = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_COINS - 1);
    localparam logic [gcm_pkg::DIV_CNT_W-1:0] LAST_STEP =
        gcm_pkg::DIV_CNT_W'(gcm_pkg::DIV_STEPS - 1);

    gcm_pkg::gcm_state_t state_reg, state_next;

    logic [gcm_pkg::COIN_W-1:0]     coin_reg [gcm_pkg::SLOT_REGS];
    logic [gcm_pkg::CENTS_W-1:0]    rest_reg, rest_next;
    logic [gcm_pkg::CENTS_W-1:0]    quo_reg, quo_next;
    logic [gcm_pkg::COIN_W-1:0]     rem_reg, rem_next;
    logic [gcm_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;

    logic [gcm_pkg::COIN_W-1:0]     denom;
    logic [gcm_pkg::COIN_W:0]       div_trial;
    logic                           div_fit;
    logic [gcm_pkg::COIN_W-1:0]     rem_step;
    logic                           is_last;
    logic                           in_xfer;
    logic                           out_xfer;

    // Denomination of the slot in work
    assign denom   = coin_reg[gcm_pkg::SLOT_IDX_W'(slot_reg)];
    assign is_last = (slot_reg == LAST_SLOT);

    // Shared divider step: shift in the next dividend bit, trial subtract
    assign div_trial = {rem_reg, quo_reg[gcm_pkg::CENTS_W-1]} - {1'b0, denom};
    assign div_fit   = ~div_trial[gcm_pkg::COIN_W];
    assign rem_step  = div_fit ? div_trial[gcm_pkg::COIN_W-1:0]
                               : {rem_reg[gcm_pkg::COIN_W-2:0],
                                  quo_reg[gcm_pkg::CENTS_W-1]};

    assign in_xfer  = request.valid && request.ready;
    assign out_xfer = result.valid && result.ready;

    // Hold denominations; writes must arrive only while idle (the block does not enforce this)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gcm_pkg::SLOT_REGS; i++)
            begin
                coin_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            coin_reg[cfg_index] <= cfg_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gcm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = gcm_pkg::ST_START;
                end
            end
            gcm_pkg::ST_START:
            begin
                state_next = (denom == '0) ? gcm_pkg::ST_EMIT : gcm_pkg::ST_DIV;
            end
            gcm_pkg::ST_DIV:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = gcm_pkg::ST_EMIT;
                end
            end
            gcm_pkg::ST_EMIT:
            begin
                if (out_xfer)
                begin
                    state_next = is_last ? gcm_pkg::ST_IDLE : gcm_pkg::ST_START;
                end
            end
            default:
            begin
                state_next = gcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath updates
    always_comb
    begin
        rest_next = rest_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        case (state_reg)
            gcm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    rest_next = request.change_cents;
                    slot_next = '0;
                end
            end
            gcm_pkg::ST_START:
            begin
                cnt_next = '0;
                rem_next = '0;
                quo_next = (denom == '0) ? '0 : rest_reg;
            end
            gcm_pkg::ST_DIV:
            begin
                rem_next = rem_step;
                quo_next = {quo_reg[gcm_pkg::CENTS_W-2:0], div_fit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    rest_next = gcm_pkg::CENTS_W'(rem_step);
                end
            end
            gcm_pkg::ST_EMIT:
            begin
                if (out_xfer && !is_last)
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            default:
            begin
                slot_next = '0;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        request.ready     = (state_reg == gcm_pkg::ST_IDLE);
        result.valid      = (state_reg == gcm_pkg::ST_EMIT);
        result.slot_index = gcm_pkg::SLOT_IDX_W'(slot_reg);
        result.coin_value = denom;
        result.coin_count = quo_reg;
        result.last_slot  = is_last;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcm_pkg::ST_IDLE;
            slot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    // Never take a new amount while a result is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(request.ready && result.valid))
        else $error("request ready while result valid");

    // Every amount starts at the first slot
    a_start_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == gcm_pkg::ST_START) && (slot_reg == '0))
        else $error("amount did not start at slot zero");

    // The last slot's transfer returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && result.last_slot) |=> request.ready)
        else $error("not idle after last slot");

    // A non-last transfer moves on to the next slot
    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !result.last_slot) |=>
            (slot_reg == $past(slot_reg) + 1'b1) &&
            (state_reg == gcm_pkg::ST_START))
        else $error("slot did not advance");

    // Slot index stays within the configured slot count
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot index out of range");

endmodule

/* tb/sv/tb_greedy_change_maker.sv */
// Testbench for the greedy change maker: directed and random amounts under several coin sets.
module tb_greedy_change_maker;

    localparam int NUM_COINS  = 8;
    localparam int STALL_LIMIT = 4000;

    // One slot result as it leaves the block
    typedef struct packed {
        logic [gcm_pkg::SLOT_IDX_W-1:0] slot;
        logic [gcm_pkg::COIN_W-1:0]     value;
        logic [gcm_pkg::CENTS_W-1:0]    count;
        logic                           last;
    } payout_t;

    // Predicts the payout of every accepted amount and checks the result stream
    class change_scoreboard;
        logic [gcm_pkg::COIN_W-1:0] coin_cents [NUM_COINS];
        payout_t                    payouts_due [$];
        int                         errors;
        int                         amounts_seen;
        int                         results_seen;

        // Start with every slot unused, as the block does after reset
        function new();
            foreach (coin_cents[i])
                coin_cents[i] = '0;
            errors       = 0;
            amounts_seen = 0;
            results_seen = 0;
        endfunction

        function void set_coin(input int idx, input logic [gcm_pkg::COIN_W-1:0] cents);
            coin_cents[idx] = cents;
        endfunction

        function int pending();
            return payouts_due.size();
        endfunction

        // Walk the slots greedily and queue one payout per slot
        function void note_amount(input logic [gcm_pkg::CENTS_W-1:0] cents);
            logic [gcm_pkg::CENTS_W-1:0] rest;
            logic [gcm_pkg::CENTS_W-1:0] denom;
            payout_t                     p;
            rest = cents;
            amounts_seen++;
            for (int i = 0; i < NUM_COINS; i++)
            begin
                denom   = {{(gcm_pkg::CENTS_W-gcm_pkg::COIN_W){1'b0}}, coin_cents[i]};
                p.slot  = i[gcm_pkg::SLOT_IDX_W-1:0];
                p.value = coin_cents[i];
                p.count = '0;
                if (denom != 0)
                begin
                    p.count = rest / denom;
                    rest    = rest % denom;
                end
                p.last = (i == NUM_COINS - 1);
                payouts_due = {payouts_due, p};
            end
        endfunction

        task report(input string what);
            errors++;
            $display("ERROR: %s", what);
        endtask

        // Compare one result transfer with the oldest payout due
        task check_result(input payout_t got);
            payout_t want;
            results_seen++;
            if (payouts_due.size() == 0)
            begin
                report($sformatf("unexpected result slot %0d count %0d",
                                 got.slot, got.count));
                return;
            end
            want = payouts_due.pop_front();
            if (got.slot !== want.slot)
                report($sformatf("slot_index got %0d want %0d", got.slot, want.slot));
            if (got.value !== want.value)
                report($sformatf("slot %0d coin_value got %0d want %0d",
                                 want.slot, got.value, want.value));
            if (got.count !== want.count)
                report($sformatf("slot %0d coin_count got %0d want %0d",
                                 want.slot, got.count, want.count));
            if (got.last !== want.last)
                report($sformatf("slot %0d last_slot got %0b want %0b",
                                 want.slot, got.last, want.last));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [gcm_pkg::SLOT_IDX_W-1:0] cfg_index;
    logic [gcm_pkg::COIN_W-1:0]     cfg_data;

    gcm_in_if  req_if ();
    gcm_out_if res_if ();

    change_scoreboard sb;
    int               send_idle_pct = 35;
    int               recv_idle_pct = 70;
    int               quiet_cycles  = 0;
    int               coin_sets     = 0;

    greedy_change_maker #(
        .NUM_COINS (NUM_COINS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_if.sink),
        .result    (res_if.source)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Drive result ready, stalling at the current receiver rate
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result({res_if.slot_index, res_if.coin_value,
                             res_if.coin_count, res_if.last_slot});
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one amount, idling first at the current sender rate, and hold until transfer
    task send_amount(input logic [gcm_pkg::CENTS_W-1:0] cents);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.change_cents <= cents;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_amount(cents);
    endtask

    // Drop valid, drain all payouts due, then let the block settle
    task quiesce(input int settle_cycles);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    // Write all eight denominations, one per cycle
    task load_coins(input logic [gcm_pkg::COIN_W-1:0] coins [NUM_COINS]);
        for (int i = 0; i < NUM_COINS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[gcm_pkg::SLOT_IDX_W-1:0];
            cfg_data  <= coins[i];
            @(posedge clk);
            sb.set_coin(i, coins[i]);
        end
        cfg_we <= 1'b0;
        coin_sets++;
    endtask

    initial
    begin
        logic [gcm_pkg::COIN_W-1:0]  coins [NUM_COINS];
        logic [gcm_pkg::CENTS_W-1:0] cents;
        sb = new();
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        req_if.valid        <= 1'b0;
        req_if.change_cents <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All slots unused after reset: every count is zero
        send_amount(24'd0);
        send_amount(24'hFFFFFF);
        send_amount(24'd12345);

        // Ordinary coin set, covering every amount exactly
        quiesce(4);
        coins = '{16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1};
        load_coins(coins);
        send_amount(24'd0);
        send_amount(24'd1);
        send_amount(24'd388);
        send_amount(24'hFFFFFF);
        send_amount(24'd199);
        send_amount(24'd3);

        // Largest denominations mixed with unused slots
        quiesce(4);
        coins = '{16'hFFFF, 16'd0, 16'h8000, 16'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF};
        load_coins(coins);
        send_amount(24'hFFFFFF);
        send_amount(24'd65535);
        send_amount(24'd65534);
        send_amount(24'd32768);
        send_amount(24'd98303);

        // Sparse set where a remainder is left over and dropped
        quiesce(4);
        coins = '{16'd0, 16'd10000, 16'd0, 16'd300, 16'd0, 16'd7, 16'd0, 16'd3};
        load_coins(coins);
        send_amount(24'hFFFFFF);
        send_amount(24'd2);
        send_amount(24'd10312);
        send_amount(24'd299);
        send_amount(24'd65535);

        // Random coin sets and amounts, stepping through the idle patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            quiesce(4);
            send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 70 : 0;
            recv_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 35 : 0;
            for (int k = 0; k < NUM_COINS; k++)
            begin
                case ($urandom_range(4))
                    0:       coins[k] = '0;
                    1:       coins[k] = gcm_pkg::COIN_W'($urandom_range(1, 20));
                    2:       coins[k] = gcm_pkg::COIN_W'($urandom_range(1, 1000));
                    default: coins[k] = gcm_pkg::COIN_W'($urandom_range(1, 65535));
                endcase
            end
            load_coins(coins);
            repeat (65)
            begin
                case ($urandom_range(3))
                    0:       cents = gcm_pkg::CENTS_W'($urandom_range(0, 1000));
                    1:       cents = gcm_pkg::CENTS_W'($urandom);
                    2:       cents = gcm_pkg::CENTS_W'($urandom_range(0, 200000));
                    default: cents = 24'hFFFFFF - gcm_pkg::CENTS_W'($urandom_range(0, 15));
                endcase
                send_amount(cents);
            end
        end

        // Drain and close
        quiesce(30);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d payouts never arrived", sb.pending()));
        $display("Run covered %0d change amounts and %0d slot results over %0d coin sets",
                 sb.amounts_seen, sb.results_seen, coin_sets + 1);
        $display("Idle patterns: sender 35/receiver 70, sender 70/receiver 35, none");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
